// ----- hdl/dedup_fifo_queue_macros.svh -----
// ---------------------------------------------------------------------------
// dedup_fifo_queue_macros.svh
// Assertion macros shared by the duplicate-suppressing queue.
// ---------------------------------------------------------------------------
`ifndef DEDUP_FIFO_QUEUE_MACROS_SVH
`define DEDUP_FIFO_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF

// A condition that must hold at every clock edge outside reset.
`define DFQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dedup_fifo_queue: invariant violated");

// An implication checked at every clock edge outside reset.
`define DFQ_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dedup_fifo_queue: implication violated");

// A condition that must hold in the cycle after the antecedent.
`define DFQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dedup_fifo_queue: next-cycle check violated");

`else

`define DFQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define DFQ_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define DFQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/dfq_pkg.sv -----
// ---------------------------------------------------------------------------
// dfq_pkg
// Types and codes shared by the duplicate-suppressing queue.
// ---------------------------------------------------------------------------
package dfq_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned OCC_W  = 5;

    // Operation codes carried on the kind field.
    localparam logic KIND_ENQUEUE = 1'b0;
    localparam logic KIND_DEQUEUE = 1'b1;

    typedef enum logic [2:0] {
        STATUS_ENQUEUED  = 3'd0,
        STATUS_DUPLICATE = 3'd1,
        STATUS_FULL      = 3'd2,
        STATUS_DEQUEUED  = 3'd3,
        STATUS_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CTRL_IDLE,
        CTRL_SCAN,
        CTRL_FINISH
    } ctrl_state_t;

    // One result as handed from the controller to the output register.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        status_t           status;
        logic [OCC_W-1:0]  occupancy;
        logic              is_empty;
    } result_t;

endpackage

// ----- hdl/dfq_mem.sv -----
// ---------------------------------------------------------------------------
// dfq_mem
// Entry storage: one write port and one read port with registered data.
// ---------------------------------------------------------------------------
module dfq_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [dfq_pkg::DATA_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [dfq_pkg::DATA_W-1:0] rd_data
);

    logic [dfq_pkg::DATA_W-1:0] mem [DEPTH];
    logic [dfq_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read data holds until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/dfq_ctrl.sv -----
// ---------------------------------------------------------------------------
// dfq_ctrl
// Sequencer: ring pointers, duplicate scan over the store and result build.
// ---------------------------------------------------------------------------
`include "dedup_fifo_queue_macros.svh"

module dfq_ctrl #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = $clog2(DEPTH),
    parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       in_kind,
    input  logic [dfq_pkg::DATA_W-1:0] in_value,
    input  logic                       res_free,
    output logic                       res_valid,
    output dfq_pkg::result_t           res,
    output logic                       mem_wr_en,
    output logic [AW-1:0]              mem_wr_addr,
    output logic [dfq_pkg::DATA_W-1:0] mem_wr_data,
    output logic                       mem_rd_en,
    output logic [AW-1:0]              mem_rd_addr,
    input  logic [dfq_pkg::DATA_W-1:0] mem_rd_data
);

    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    dfq_pkg::ctrl_state_t state_reg, state_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [AW-1:0]              tail_reg, tail_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              issue_cnt_reg, issue_cnt_next;
    logic [AW-1:0]              rd_pos_reg, rd_pos_next;
    logic                       cmp_pend_reg, cmp_pend_next;
    logic                       dup_reg, dup_next;
    logic                       kind_reg, kind_next;
    logic [dfq_pkg::DATA_W-1:0] value_reg, value_next;

    logic                       accept;

    assign in_stall = (state_reg != dfq_pkg::CTRL_IDLE);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dfq_pkg::CTRL_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            issue_cnt_reg <= '0;
            rd_pos_reg    <= '0;
            cmp_pend_reg  <= 1'b0;
            dup_reg       <= 1'b0;
            kind_reg      <= dfq_pkg::KIND_ENQUEUE;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_pos_reg    <= rd_pos_next;
            cmp_pend_reg  <= cmp_pend_next;
            dup_reg       <= dup_next;
            kind_reg      <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        issue_cnt_next = issue_cnt_reg;
        rd_pos_next    = rd_pos_reg;
        cmp_pend_next  = cmp_pend_reg;
        dup_next       = dup_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = head_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = tail_reg;
        mem_wr_data    = value_reg;
        res_valid      = 1'b0;
        res.value      = '1;
        res.status     = dfq_pkg::STATUS_EMPTY;
        res.occupancy  = dfq_pkg::OCC_W'(count_reg);
        res.is_empty   = (count_reg == '0);

        case (state_reg)
            dfq_pkg::CTRL_IDLE:
            begin
                if (accept)
                begin
                    kind_next      = in_kind;
                    value_next     = in_value;
                    dup_next       = 1'b0;
                    issue_cnt_next = '0;
                    rd_pos_next    = head_reg;
                    cmp_pend_next  = 1'b0;
                    if (in_kind == dfq_pkg::KIND_DEQUEUE)
                    begin
                        // Fetch the oldest entry; its data is ready in the next state.
                        mem_rd_en  = (count_reg != '0);
                        state_next = dfq_pkg::CTRL_FINISH;
                    end
                    else
                    begin
                        state_next = dfq_pkg::CTRL_SCAN;
                    end
                end
            end

            dfq_pkg::CTRL_SCAN:
            begin
                if (cmp_pend_reg && (mem_rd_data == value_reg))
                begin
                    dup_next      = 1'b1;
                    cmp_pend_next = 1'b0;
                    state_next    = dfq_pkg::CTRL_FINISH;
                end
                else if (issue_cnt_reg != count_reg)
                begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = rd_pos_reg;
                    rd_pos_next    = (rd_pos_reg == LAST_POS) ? '0 : rd_pos_reg + 1'b1;
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    cmp_pend_next  = 1'b1;
                end
                else
                begin
                    cmp_pend_next = 1'b0;
                    state_next    = dfq_pkg::CTRL_FINISH;
                end
            end

            dfq_pkg::CTRL_FINISH:
            begin
                if (res_free)
                begin
                    res_valid  = 1'b1;
                    state_next = dfq_pkg::CTRL_IDLE;
                    if (kind_reg == dfq_pkg::KIND_DEQUEUE)
                    begin
                        if (count_reg == '0)
                        begin
                            res.status = dfq_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            res.status = dfq_pkg::STATUS_DEQUEUED;
                            res.value  = mem_rd_data;
                            head_next  = (head_reg == LAST_POS) ? '0 : head_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    else if (dup_reg)
                    begin
                        res.status = dfq_pkg::STATUS_DUPLICATE;
                    end
                    else if (count_reg == FULL_CNT)
                    begin
                        res.status = dfq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        res.status = dfq_pkg::STATUS_ENQUEUED;
                        mem_wr_en  = 1'b1;
                        tail_next  = (tail_reg == LAST_POS) ? '0 : tail_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    res.occupancy = dfq_pkg::OCC_W'(count_next);
                    res.is_empty  = (count_next == '0);
                end
            end

            default:
            begin
                state_next = dfq_pkg::CTRL_IDLE;
            end
        endcase
    end

    `DFQ_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= FULL_CNT)
    `DFQ_ASSERT_IMPLIES(a_scan_bound, clk, rst_n, state_reg == dfq_pkg::CTRL_SCAN, issue_cnt_reg <= count_reg)
    `DFQ_ASSERT_IMPLIES(a_empty_ptrs, clk, rst_n, count_reg == '0, head_reg == tail_reg)
    `DFQ_ASSERT_IMPLIES(a_write_with_result, clk, rst_n, mem_wr_en, res_valid && (kind_reg == dfq_pkg::KIND_ENQUEUE))
    `DFQ_ASSERT_NEXT(a_enq_count, clk, rst_n, res_valid && (res.status == dfq_pkg::STATUS_ENQUEUED), count_reg == $past(count_reg) + 1'b1)

endmodule

// ----- hdl/dedup_fifo_queue.sv -----
// ---------------------------------------------------------------------------
// dedup_fifo_queue
// First-in first-out queue of 64-bit signed values that drops duplicates.
// ---------------------------------------------------------------------------
// A queue of up to DEPTH signed 64-bit values held in a ring in one synchronous
// memory. Every transfer on the input gives exactly one transfer on the output.
// An enqueue (kind 0) compares its value with every held entry, reading the
// memory one entry per cycle from the oldest onwards; a match drops the value
// with status 1, a full queue drops it with status 2, otherwise it is written
// at the tail with status 0. A dequeue (kind 1) returns the oldest value with
// status 3, or -1 with status 4 when the queue is empty. Every result also
// reports the occupancy after the operation (modulo 32) and an empty flag;
// out_value is -1 for all enqueue results. One item is in progress at a time:
// an enqueue holds off the next input transfer until its duplicate scan,
// which reads one entry per cycle through the single memory read port, is
// done and its result is handed over; a scan stops early on the first match.
// A dequeue fetches the oldest entry and then finishes. The output register
// lets the next input transfer take place while a result still waits there.
// No clearing pass is needed after reset, as only held entries are ever read.
// ---------------------------------------------------------------------------
module dedup_fifo_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic signed [63:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] out_value,
    output logic [2:0]         status,
    output logic [4:0]         occupancy,
    output logic               is_empty
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic                       mem_wr_en;
    logic [AW-1:0]              mem_wr_addr;
    logic [dfq_pkg::DATA_W-1:0] mem_wr_data;
    logic                       mem_rd_en;
    logic [AW-1:0]              mem_rd_addr;
    logic [dfq_pkg::DATA_W-1:0] mem_rd_data;

    logic                       res_valid;
    logic                       res_free;
    dfq_pkg::result_t           res;

    // Output register: holds one finished result until its transfer completes.
    logic                       out_valid_reg, out_valid_next;
    dfq_pkg::result_t           out_res_reg, out_res_next;

    // The controller may hand over a new result when the register is empty or
    // is being emptied in this cycle.
    assign res_free = !out_valid_reg || !out_stall;

    dfq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    dfq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_kind     (kind),
        .in_value    (value),
        .res_free    (res_free),
        .res_valid   (res_valid),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_res_reg.value;
    assign status    = out_res_reg.status;
    assign occupancy = out_res_reg.occupancy;
    assign is_empty  = out_res_reg.is_empty;

endmodule

// ----- bench/tb_dedup_fifo_queue.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_dedup_fifo_queue
// Self-checking bench for the duplicate-suppressing first-in first-out queue.
// ---------------------------------------------------------------------------
// A driver presents enqueue and dequeue requests from a queue of pending
// operations. Every accepted transfer is also applied to a ring model kept
// in the bench, which gives the expected value, status, occupancy and empty
// flag. A monitor takes each result transfer and checks it field by field
// against the oldest expectation. A short directed sequence covers the
// extreme values, an empty dequeue, a held -1, a full queue and a duplicate
// offered to a full queue. A long random sequence follows, built from a small
// pool of recurring values so that duplicates and full drops are common,
// under several patterns of sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module tb_dedup_fifo_queue;

    localparam int unsigned DEPTH        = 16;
    localparam int unsigned RANDOM_OPS   = 1500;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned POOL_SIZE    = 24;
    localparam int unsigned SETTLE_TIME  = 40;
    localparam int unsigned REPORT_LIMIT = 10;

    // One request waiting to be driven, together with the idling pattern
    // that applies while it is offered.
    typedef struct {
        logic        op_kind;
        logic [63:0] op_value;
        int unsigned gap_pct;
        int unsigned stall_pct;
        bit          wait_drain;
    } queue_request_t;

    typedef struct {
        logic [63:0]      value;
        dfq_pkg::status_t status;
        logic [4:0]       occupancy;
        logic             is_empty;
    } queue_result_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic               kind      = dfq_pkg::KIND_ENQUEUE;
    logic signed [63:0] value     = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [63:0] out_value;
    logic [2:0]         status;
    logic [4:0]         occupancy;
    logic               is_empty;

    queue_request_t pending_ops[$];
    queue_result_t  awaited_results[$];

    // Ring model of the queue contents.
    logic [63:0]    ring_store[DEPTH];
    int unsigned    ring_head  = 0;
    int unsigned    ring_tail  = 0;
    int unsigned    ring_count = 0;

    int unsigned    recv_stall_pct = 0;
    int unsigned    mismatch_count = 0;
    int unsigned    cycle_count    = 0;

    dedup_fifo_queue #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_value (out_value),
        .status    (status),
        .occupancy (occupancy),
        .is_empty  (is_empty)
    );

    always #5 clk = ~clk;

    // Applies one accepted request to the ring model and returns the result
    // the block should give for it. The duplicate search runs before the
    // fullness test, so a held value offered to a full queue is reported as
    // a duplicate rather than as a full drop.
    function automatic queue_result_t apply_queue_op(logic op_kind, logic [63:0] op_value);
        queue_result_t res;
        bit            found;
        int unsigned   pos;
        res.value = '1;
        found     = 1'b0;
        pos       = ring_head;
        if (op_kind == dfq_pkg::KIND_ENQUEUE)
        begin
            for (int unsigned n = 0; n < ring_count; n++)
            begin
                if (ring_store[pos] == op_value)
                    found = 1'b1;
                pos = (pos == DEPTH - 1) ? 0 : pos + 1;
            end
            if (found)
                res.status = dfq_pkg::STATUS_DUPLICATE;
            else if (ring_count >= DEPTH)
                res.status = dfq_pkg::STATUS_FULL;
            else
            begin
                ring_store[ring_tail] = op_value;
                ring_tail             = (ring_tail == DEPTH - 1) ? 0 : ring_tail + 1;
                ring_count            = ring_count + 1;
                res.status            = dfq_pkg::STATUS_ENQUEUED;
            end
        end
        else if (ring_count == 0)
            // An empty dequeue returns -1 with its own status, which is how a
            // genuinely held -1 is told apart from it.
            res.status = dfq_pkg::STATUS_EMPTY;
        else
        begin
            res.value  = ring_store[ring_head];
            ring_head  = (ring_head == DEPTH - 1) ? 0 : ring_head + 1;
            ring_count = ring_count - 1;
            res.status = dfq_pkg::STATUS_DEQUEUED;
        end
        res.occupancy = 5'(ring_count);
        res.is_empty  = (ring_count == 0);
        return res;
    endfunction

    task automatic report_field(string field_name, logic [63:0] want_bits,
                                logic [63:0] got_bits);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, got %h",
                     $time, field_name, want_bits, got_bits);
    endtask

    task automatic add_op(logic op_kind, logic [63:0] op_value, int unsigned gap_pct,
                          int unsigned stall_pct, bit wait_drain);
        queue_request_t req;
        req.op_kind    = op_kind;
        req.op_value   = op_value;
        req.gap_pct    = gap_pct;
        req.stall_pct  = stall_pct;
        req.wait_drain = wait_drain;
        pending_ops.push_back(req);
    endtask

    // Driver. A request is raised without regard to in_stall and then held,
    // payload unchanged, until its transfer takes place. Each transfer is
    // applied to the model at the same edge, so expectations queue up in
    // exactly the order in which the block sees the requests.
    always @(posedge clk)
    begin : driver
        queue_request_t req;
        bit             busy;
        if (rst_n)
        begin
            busy = in_valid;
            if (in_valid && !in_stall)
            begin
                awaited_results.push_back(apply_queue_op(kind, value));
                busy = 1'b0;
            end
            if (!busy)
            begin
                // A request marked for draining is held back until every
                // result already owed has arrived.
                if (pending_ops.size() != 0
                    && !(pending_ops[0].wait_drain && awaited_results.size() != 0)
                    && $urandom_range(99) >= pending_ops[0].gap_pct)
                begin
                    req            = pending_ops.pop_front();
                    kind          <= req.op_kind;
                    value         <= req.op_value;
                    in_valid      <= 1'b1;
                    recv_stall_pct = req.stall_pct;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor. Each result transfer is checked against the oldest
    // expectation; the receiver then decides afresh whether to stall.
    always @(posedge clk)
    begin : monitor
        queue_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result transfer with nothing outstanding, value %h",
                                 $time, out_value);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_value !== want.value)
                        report_field("out_value", want.value, out_value);
                    if (status !== want.status)
                        report_field("status", 64'(want.status), 64'(status));
                    if (occupancy !== want.occupancy)
                        report_field("occupancy", 64'(want.occupancy), 64'(occupancy));
                    if (is_empty !== want.is_empty)
                        report_field("is_empty", 64'(want.is_empty), 64'(is_empty));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [63:0] value_pool[POOL_SIZE];
        int unsigned phase;
        int unsigned gap_pct;
        int unsigned stall_pct;
        int unsigned enq_pct;
        logic        op_kind;
        logic [63:0] op_value;
        bit          wait_drain;

        // Directed part, with no idling on either side. It starts with an
        // empty dequeue, then places the extreme values and -1 in the queue,
        // offers a duplicate, fills the ring, offers a new value to the full
        // queue and a held value to the full queue, and drains the first four.
        add_op(dfq_pkg::KIND_DEQUEUE, 64'h0, 0, 0, 1'b0);
        add_op(dfq_pkg::KIND_ENQUEUE, 64'h8000_0000_0000_0000, 0, 0, 1'b0);
        add_op(dfq_pkg::KIND_ENQUEUE, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 1'b0);
        add_op(dfq_pkg::KIND_ENQUEUE, 64'h0, 0, 0, 1'b0);
        add_op(dfq_pkg::KIND_ENQUEUE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 1'b0);
        add_op(dfq_pkg::KIND_ENQUEUE, 64'h8000_0000_0000_0000, 0, 0, 1'b0);
        for (int unsigned i = 0; i < DEPTH - 4; i++)
            add_op(dfq_pkg::KIND_ENQUEUE, 64'h1 << (i * 5), 0, 0, 1'b0);
        add_op(dfq_pkg::KIND_ENQUEUE, 64'h5A5A_A5A5_C3C3_3C3C, 0, 0, 1'b0);
        add_op(dfq_pkg::KIND_ENQUEUE, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 1'b0);
        for (int unsigned i = 0; i < 4; i++)
            add_op(dfq_pkg::KIND_DEQUEUE, {$urandom, $urandom}, 0, 0, 1'b0);

        // Random part. Values come mostly from a small recurring pool, which
        // is larger than the ring, so duplicates and full drops both occur;
        // the rest are fresh 64-bit values so that every bit toggles. The
        // balance of enqueues and dequeues is drawn anew every forty requests so
        // that the queue swings between empty and full.
        enq_pct = 50;
        for (int unsigned i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 200 == 0)
                for (int unsigned k = 0; k < POOL_SIZE; k++)
                    case ($urandom_range(7))
                        0:       value_pool[k] = 64'h0;
                        1:       value_pool[k] = 64'hFFFF_FFFF_FFFF_FFFF;
                        2:       value_pool[k] = 64'h8000_0000_0000_0000;
                        3:       value_pool[k] = 64'h7FFF_FFFF_FFFF_FFFF;
                        default: value_pool[k] = {$urandom, $urandom};
                    endcase
            if (i % 40 == 0)
                case ($urandom_range(2))
                    0:       enq_pct = 80;
                    1:       enq_pct = 50;
                    default: enq_pct = 25;
                endcase

            // Idling patterns in turn: none, sender gaps, receiver stalls,
            // then light idling on both sides.
            phase = (i / 190) % 4;
            case (phase)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 72; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 72; end
                default: begin gap_pct = 16; stall_pct = 16; end
            endcase

            op_kind = ($urandom_range(99) < enq_pct) ? dfq_pkg::KIND_ENQUEUE
                                                     : dfq_pkg::KIND_DEQUEUE;
            if ($urandom_range(99) < 60)
                op_value = value_pool[$urandom_range(POOL_SIZE - 1)];
            else
                op_value = {$urandom, $urandom};
            wait_drain = (i % 250 == 125);
            add_op(op_kind, op_value, gap_pct, stall_pct, wait_drain);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || in_valid)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TIME) @(posedge clk);

        if (awaited_results.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
